// ===== rtl/core/tiu_pkg.sv =====
// ----------------------------------------------------------------------------
// tiu_pkg
// Types, register indexes and constants shared by the timer and interrupt unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tiu_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_TIMER_ENABLE     = 2'd0;
    localparam logic [1:0] REG_CLOCK_SELECT     = 2'd1;
    localparam logic [1:0] REG_RELOAD_VALUE     = 2'd2;
    localparam logic [1:0] REG_INTERRUPT_ENABLE = 2'd3;

    // Clock select codes.
    localparam logic [1:0] CLK_SEL_256 = 2'd0;
    localparam logic [1:0] CLK_SEL_4   = 2'd1;
    localparam logic [1:0] CLK_SEL_16  = 2'd2;
    localparam logic [1:0] CLK_SEL_64  = 2'd3;

    localparam int NUM_SOURCES = 5;

    // The timer prescaler can briefly hold up to 255 + 15 after a period change.
    localparam int TIMER_PW = 9;

    localparam int FLAG_TIMER_BIT = 2;

    localparam logic [6:0] VECTOR_BASE = 7'h40;

    typedef logic [NUM_SOURCES-1:0] flags_t;

    typedef struct packed {
        flags_t     flags;
        logic       taken;
        logic [6:0] vector;
        logic       pending;
    } dispatch_t;

    function automatic logic [TIMER_PW-1:0] timer_period(input logic [1:0] sel);
        logic [TIMER_PW-1:0] period;
        case (sel)
            CLK_SEL_256: period = 9'd256;
            CLK_SEL_4:   period = 9'd4;
            CLK_SEL_16:  period = 9'd16;
            CLK_SEL_64:  period = 9'd64;
            default:     period = 9'd256;
        endcase
        return period;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tiu_irq_select.sv =====
// ----------------------------------------------------------------------------
// tiu_irq_select
// Picks the lowest pending enabled interrupt and, when allowed, clears it and forms its vector.
// ----------------------------------------------------------------------------
`default_nettype none

module tiu_irq_select (
    input  wire tiu_pkg::flags_t flags_i,
    input  wire tiu_pkg::flags_t enable_i,
    input  wire logic            allow_i,
    output tiu_pkg::dispatch_t   result_o
);

    tiu_pkg::flags_t active;
    tiu_pkg::flags_t remaining;
    logic            found;
    logic [2:0]      bit_idx;

    always_comb begin
        active  = flags_i & enable_i;
        found   = 1'b0;
        bit_idx = 3'd0;
        // Scan from the top so that the lowest set bit wins.
        for (int i = tiu_pkg::NUM_SOURCES - 1; i >= 0; i--) begin
            if (active[i]) begin
                found   = 1'b1;
                bit_idx = 3'(i);
            end
        end

        remaining = flags_i;
        if (allow_i && found) begin
            remaining[bit_idx] = 1'b0;
        end

        result_o.flags   = remaining;
        result_o.taken   = allow_i && found;
        result_o.vector  = (allow_i && found) ?
                           (tiu_pkg::VECTOR_BASE + {1'b0, bit_idx, 3'b000}) : 7'd0;
        result_o.pending = |(remaining & enable_i);
    end

endmodule

`default_nettype wire

// ===== rtl/core/timer_interrupt_unit_top.sv =====
// ----------------------------------------------------------------------------
// timer_interrupt_unit_top
// Divider, programmable timer and five-source interrupt selector.
// ----------------------------------------------------------------------------
// The CPU sends one word per executed instruction on the s_ channel. With
// s_tuser low the word is a step: its request bits are ORed into the flags,
// its elapsed cycles advance the divider and, when enabled, the timer, and
// then the lowest pending enabled interrupt is dispatched if master enable
// is set. With s_tuser high the word simply replaces the interrupt flags.
// Every input word produces exactly one result word on the m_ channel with
// the divider, timer, flags, the dispatch outcome and the pending indication.
//
// The prescalers are worked off by one subtract-and-count step per clock, so
// the time from acceptance to the result grows with the larger number of
// divider or timer ticks a step causes: normally 0 to 4, and up to 67 right
// after the timer period is shortened. A flag write skips the run state.
// s_tready is high only while the unit is idle.
//
// A finished result sits in an output register; the unit accepts a new word
// while it waits, but holds the next result until the receiver takes the
// previous one. Reset clears all counters, flags and configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module timer_interrupt_unit_top #(
    parameter int DIVIDER_PERIOD = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata,

    // Input channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata, from bit 0: elapsed_cycles[3:0], master_enable, request_bits[4:0],
    // flag_value[4:0], one zero pad bit.
    input  wire logic [15:0] s_tdata,
    // tuser: cmd (0 = step, 1 = write flags).
    input  wire logic        s_tuser,

    // Result channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata, from bit 0: divider_value[7:0], timer_value[7:0], flags_value[4:0],
    // taken, vector[6:0], pending, two zero pad bits.
    output logic [31:0]      m_tdata
);

    // Wide enough for a prescaler value below the period plus one step of cycles.
    localparam int DPW = $clog2(DIVIDER_PERIOD + 16);
    localparam logic [DPW-1:0] DIV_PERIOD = DPW'(DIVIDER_PERIOD);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t                        state_reg, state_next;

    logic                          timer_enable_reg, timer_enable_next;
    logic [1:0]                    clock_select_reg, clock_select_next;
    logic [7:0]                    reload_value_reg, reload_value_next;
    tiu_pkg::flags_t               irq_enable_reg, irq_enable_next;

    logic [DPW-1:0]                div_pre_reg, div_pre_next;
    logic [7:0]                    div_cnt_reg, div_cnt_next;
    logic [tiu_pkg::TIMER_PW-1:0]  tim_pre_reg, tim_pre_next;
    logic [7:0]                    tim_cnt_reg, tim_cnt_next;
    tiu_pkg::flags_t               flags_reg, flags_next;

    logic                          cmd_reg, cmd_next;
    logic                          ime_reg, ime_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [31:0]                   m_tdata_reg, m_tdata_next;

    logic [tiu_pkg::TIMER_PW-1:0]  period;
    logic                          div_tick;
    logic                          tim_tick;
    tiu_pkg::dispatch_t            dispatch;

    // Input word fields.
    logic [3:0]                    in_cycles;
    logic                          in_ime;
    tiu_pkg::flags_t               in_req;
    tiu_pkg::flags_t               in_fval;

    assign in_cycles = s_tdata[3:0];
    assign in_ime    = s_tdata[4];
    assign in_req    = s_tdata[9:5];
    assign in_fval   = s_tdata[14:10];

    assign period   = tiu_pkg::timer_period(clock_select_reg);
    assign div_tick = (div_pre_reg >= DIV_PERIOD);
    assign tim_tick = timer_enable_reg && (tim_pre_reg >= period);

    // Dispatch is only allowed for a step word with master enable set.
    tiu_irq_select u_irq_select (
        .flags_i  (flags_reg),
        .enable_i (irq_enable_reg),
        .allow_i  (ime_reg && !cmd_reg),
        .result_o (dispatch)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next        = state_reg;
        timer_enable_next = timer_enable_reg;
        clock_select_next = clock_select_reg;
        reload_value_next = reload_value_reg;
        irq_enable_next   = irq_enable_reg;
        div_pre_next      = div_pre_reg;
        div_cnt_next      = div_cnt_reg;
        tim_pre_next      = tim_pre_reg;
        tim_cnt_next      = tim_cnt_reg;
        flags_next        = flags_reg;
        cmd_next          = cmd_reg;
        ime_next          = ime_reg;
        m_tvalid_next     = m_tvalid_reg;
        m_tdata_next      = m_tdata_reg;

        if (cfg_we) begin
            case (cfg_index)
                tiu_pkg::REG_TIMER_ENABLE:     timer_enable_next = cfg_wdata[0];
                tiu_pkg::REG_CLOCK_SELECT:     clock_select_next = cfg_wdata[1:0];
                tiu_pkg::REG_RELOAD_VALUE:     reload_value_next = cfg_wdata;
                tiu_pkg::REG_INTERRUPT_ENABLE: irq_enable_next   = cfg_wdata[4:0];
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next = s_tuser;
                    ime_next = in_ime;
                    if (s_tuser) begin
                        flags_next = in_fval;
                        state_next = ST_DONE;
                    end else begin
                        flags_next   = flags_reg | in_req;
                        div_pre_next = div_pre_reg + DPW'(in_cycles);
                        if (timer_enable_reg) begin
                            tim_pre_next = tim_pre_reg + tiu_pkg::TIMER_PW'(in_cycles);
                        end
                        state_next = ST_RUN;
                    end
                end
            end

            ST_RUN: begin
                // One tick of each prescaler per cycle until both are below period.
                if (div_tick) begin
                    div_pre_next = div_pre_reg - DIV_PERIOD;
                    div_cnt_next = div_cnt_reg + 8'd1;
                end
                if (tim_tick) begin
                    tim_pre_next = tim_pre_reg - period;
                    if (tim_cnt_reg == 8'hFF) begin
                        tim_cnt_next = reload_value_reg;
                        flags_next[tiu_pkg::FLAG_TIMER_BIT] = 1'b1;
                    end else begin
                        tim_cnt_next = tim_cnt_reg + 8'd1;
                    end
                end
                if (!div_tick && !tim_tick) begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    flags_next    = dispatch.flags;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, dispatch.pending, dispatch.vector,
                                     dispatch.taken, dispatch.flags,
                                     tim_cnt_reg, div_cnt_reg};
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            timer_enable_reg <= 1'b0;
            clock_select_reg <= 2'd0;
            reload_value_reg <= 8'd0;
            irq_enable_reg   <= '0;
            div_pre_reg      <= '0;
            div_cnt_reg      <= 8'd0;
            tim_pre_reg      <= '0;
            tim_cnt_reg      <= 8'd0;
            flags_reg        <= '0;
            cmd_reg          <= 1'b0;
            ime_reg          <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            timer_enable_reg <= timer_enable_next;
            clock_select_reg <= clock_select_next;
            reload_value_reg <= reload_value_next;
            irq_enable_reg   <= irq_enable_next;
            div_pre_reg      <= div_pre_next;
            div_cnt_reg      <= div_cnt_next;
            tim_pre_reg      <= tim_pre_next;
            tim_cnt_reg      <= tim_cnt_next;
            flags_reg        <= flags_next;
            cmd_reg          <= cmd_next;
            ime_reg          <= ime_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

endmodule

`default_nettype wire
